FILE: sv/pwmpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pwmpa_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAX,
    ST_CAP,
    ST_ALLOC,
    ST_CHECK,
    ST_RESP
  } state_t;

  // Modes of the shared step unit
  typedef enum logic [1:0] {
    MODE_MAX,
    MODE_CAP,
    MODE_ALLOC,
    MODE_CHECK
  } mode_t;

  // Operation codes
  localparam logic [2:0] OP_WRITE_DUTY  = 3'd0;
  localparam logic [2:0] OP_RECOMPUTE   = 3'd1;
  localparam logic [2:0] OP_CHECK_HALF  = 3'd2;
  localparam logic [2:0] OP_CHANGE_REQ  = 3'd3;
  localparam logic [2:0] OP_CHANGE_RST  = 3'd4;
  localparam logic [2:0] OP_READ_CHAN   = 3'd5;
  localparam logic [2:0] OP_READ_STATUS = 3'd6;

  // Configuration register indexes
  localparam logic [2:0] CFG_ACTIVE     = 3'd0;
  localparam logic [2:0] CFG_MIN_HALF   = 3'd1;
  localparam logic [2:0] CFG_MAX_HALF   = 3'd2;
  localparam logic [2:0] CFG_START_HALF = 3'd3;
  localparam logic [2:0] CFG_INDEP_MASK = 3'd4;

  // Status codes
  localparam logic [1:0] STATUS_NONE      = 2'd0;
  localparam logic [1:0] STATUS_SAME_FREQ = 2'd1;
  localparam logic [1:0] STATUS_RESTORE   = 2'd2;

  localparam logic [15:0] CHANGE_LIMIT = 16'd10;

  // Reset values
  localparam logic [2:0]  RST_ACTIVE       = 3'd4;
  localparam logic [14:0] RST_MIN_HALF     = 15'd1000;
  localparam logic [14:0] RST_MAX_HALF     = 15'd4000;
  localparam logic [15:0] RST_START_HALF   = 16'd2000;
  localparam logic [15:0] RST_START_PERIOD = 16'd4000;

  // Step unit operands
  typedef struct packed {
    mode_t       mode;
    logic [15:0] half;
    logic [15:0] top;
    logic [14:0] min_half;
    logic [14:0] max_half;
    logic [15:0] shared;
    logic        indep;
  } step_in_t;

  // Step unit results
  typedef struct packed {
    logic [15:0] top;
    logic [15:0] shared;
    logic [15:0] half;
    logic [15:0] period;
    logic        over_half;
  } step_out_t;

endpackage

`default_nettype wire

FILE: sv/pwmpa_step_unit.sv
`timescale 1ns / 1ps
`default_nettype none

module pwmpa_step_unit (
  input  wire pwmpa_pkg::step_in_t  op_i,
  output pwmpa_pkg::step_out_t      res_o
);

  logic [15:0] floored;
  logic [15:0] capped;
  logic [16:0] even;
  logic [15:0] lim;
  logic [15:0] thr;

  always_comb begin
    // floor, cap, round-up-to-even and half/threshold terms
    floored = (op_i.half < {1'b0, op_i.min_half}) ? {1'b0, op_i.min_half} : op_i.half;
    capped  = (op_i.top > {1'b0, op_i.max_half}) ? {1'b0, op_i.max_half} : op_i.top;
    even    = {1'b0, capped} + {16'd0, capped[0]};
    lim     = op_i.shared >> 1;
    thr     = lim - 16'd2;

    res_o.top       = op_i.top;
    res_o.shared    = op_i.shared;
    res_o.half      = op_i.half;
    res_o.period    = op_i.shared;
    res_o.over_half = 1'b0;

    unique case (op_i.mode)
      pwmpa_pkg::MODE_MAX: begin
        res_o.top = (floored > op_i.top) ? floored : op_i.top;
      end
      pwmpa_pkg::MODE_CAP: begin
        // doubling wraps at 16 bits
        res_o.shared = {even[14:0], 1'b0};
      end
      pwmpa_pkg::MODE_ALLOC: begin
        if (op_i.indep) begin
          res_o.period = {op_i.half[14:0], 1'b0};
        end else begin
          res_o.period = op_i.shared;
          res_o.half   = (op_i.half > lim) ? lim : op_i.half;
        end
      end
      pwmpa_pkg::MODE_CHECK: begin
        res_o.over_half = (op_i.half >= thr);
      end
      default: begin
        res_o.top = op_i.top;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/multichannel_pwm_period_allocator_unit.sv
`timescale 1ns / 1ps
`default_nettype none

// Multichannel PWM period allocator.
// Input channel: a request (in_operation, in_channel, in_duty_value, in_change_in,
// in_converter_busy) is taken at a rising edge with start high and busy low.
// Every request produces exactly one result, shown for one cycle with out_valid.
// Configuration: cfg_valid/cfg_ready write channel, cfg_index selects the register,
// cfg_data carries the value; cfg_ready is always high. Write only while idle.
// Sequence from accept to out_valid, with n = min(active_channels, NUM_CHANNELS):
//   recompute (not busy): max walk over n channels, cap, allocate walk over n
//   check half duty:      one compare per channel
//   all other requests:   result step only
// One shared step unit serves every channel step, so the walks set the rate;
// busy stays high until the result cycle, when the next request may be taken.
// The receiver cannot stall: a result is lost if not taken in its cycle.
// Reset (rst_n low, synchronous) loads the register defaults, each channel
// half-period with 2000 and period with 4000, and clears shared period, flags, count
// and status. start_half_period is accepted but only matters at reset, where
// its default applies.
module multichannel_pwm_period_allocator_unit #(
  parameter int NUM_CHANNELS = 4
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  output logic        busy,
  input  wire  [2:0]  in_operation,
  input  wire  [1:0]  in_channel,
  input  wire  [15:0] in_duty_value,
  input  wire         in_change_in,
  input  wire         in_converter_busy,
  output logic        out_valid,
  output logic [15:0] out_shared_period,
  output logic [15:0] out_channel_period,
  output logic [15:0] out_channel_half,
  output logic        out_channel_over_half,
  output logic        out_change_out,
  output logic [1:0]  out_status_code,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [2:0]  cfg_index,
  input  wire  [14:0] cfg_data
);

  localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int NW = $clog2(NUM_CHANNELS + 1);
  localparam int IW = ((CW > 2) ? CW : 2) + 1;

  // Sequencer and request registers
  pwmpa_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic [1:0]        ch_r, ch_nxt;
  logic              chg_r, chg_nxt;
  logic [1:0]        stat_r, stat_nxt;
  logic [15:0]       top_r, top_nxt;

  // Block state
  logic [15:0] shared_r, shared_nxt;
  logic [15:0] half_r   [NUM_CHANNELS];
  logic [15:0] half_nxt [NUM_CHANNELS];
  logic [15:0] period_r   [NUM_CHANNELS];
  logic [15:0] period_nxt [NUM_CHANNELS];
  logic        flag_r   [NUM_CHANNELS];
  logic        flag_nxt [NUM_CHANNELS];
  logic [15:0] cnt_r, cnt_nxt;
  logic [1:0]  pend_r, pend_nxt;

  // Configuration
  logic [2:0]  cfg_active_r;
  logic [14:0] cfg_min_r;
  logic [14:0] cfg_max_r;
  logic [3:0]  cfg_mask_r;

  // Result registers
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_shared_r, out_shared_nxt;
  logic [15:0] out_period_r, out_period_nxt;
  logic [15:0] out_half_r, out_half_nxt;
  logic        out_over_r, out_over_nxt;
  logic        out_chg_r, out_chg_nxt;
  logic [1:0]  out_stat_r, out_stat_nxt;

  logic [NW-1:0]        live;
  logic                 last;
  logic                 accept;
  logic [CW-1:0]        rd_idx;
  logic [7:0]           mask8;
  pwmpa_pkg::step_in_t  step_in;
  pwmpa_pkg::step_out_t step_out;

  function automatic logic chan_ok(input logic [1:0] ch);
    chan_ok = IW'(ch) < IW'(NUM_CHANNELS);
  endfunction

  assign cfg_ready = 1'b1;
  assign busy      = (state_r != pwmpa_pkg::ST_IDLE);
  assign accept    = start && !busy;

  // Live channel count, capped at the channel count
  assign live = ({1'b0, cfg_active_r} > 4'(NUM_CHANNELS)) ? NW'(NUM_CHANNELS)
                                                            : NW'(cfg_active_r);
  assign last = (NW'(idx_r) + NW'(1)) == live;

  // One read port: walk index during sequences, request channel in the result step
  assign rd_idx = (state_r == pwmpa_pkg::ST_RESP) ? CW'(ch_r) : idx_r;
  assign mask8  = {4'd0, cfg_mask_r};

  // Shared step unit
  always_comb begin
    step_in.half     = half_r[rd_idx];
    step_in.top      = top_r;
    step_in.min_half = cfg_min_r;
    step_in.max_half = cfg_max_r;
    step_in.shared   = shared_r;
    step_in.indep    = mask8[3'(idx_r)];
    unique case (state_r)
      pwmpa_pkg::ST_CAP:   step_in.mode = pwmpa_pkg::MODE_CAP;
      pwmpa_pkg::ST_ALLOC: step_in.mode = pwmpa_pkg::MODE_ALLOC;
      pwmpa_pkg::ST_CHECK: step_in.mode = pwmpa_pkg::MODE_CHECK;
      default:             step_in.mode = pwmpa_pkg::MODE_MAX;
    endcase
  end

  pwmpa_step_unit u_step (
    .op_i  (step_in),
    .res_o (step_out)
  );

  // Sequencer: next state and datapath updates
  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    ch_nxt         = ch_r;
    chg_nxt        = chg_r;
    stat_nxt       = stat_r;
    top_nxt        = top_r;
    shared_nxt     = shared_r;
    half_nxt       = half_r;
    period_nxt     = period_r;
    flag_nxt       = flag_r;
    cnt_nxt        = cnt_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = 1'b0;
    out_shared_nxt = out_shared_r;
    out_period_nxt = out_period_r;
    out_half_nxt   = out_half_r;
    out_over_nxt   = out_over_r;
    out_chg_nxt    = out_chg_r;
    out_stat_nxt   = out_stat_r;

    unique case (state_r)
      pwmpa_pkg::ST_IDLE: begin
        if (accept) begin
          ch_nxt    = in_channel;
          idx_nxt   = '0;
          top_nxt   = '0;
          chg_nxt   = 1'b0;
          stat_nxt  = pwmpa_pkg::STATUS_NONE;
          state_nxt = pwmpa_pkg::ST_RESP;
          unique case (in_operation)
            pwmpa_pkg::OP_WRITE_DUTY: begin
              if (chan_ok(in_channel)) begin
                half_nxt[CW'(in_channel)] = in_duty_value;
              end
            end
            pwmpa_pkg::OP_RECOMPUTE: begin
              if (!in_converter_busy) begin
                chg_nxt   = in_change_in;
                state_nxt = (live == '0) ? pwmpa_pkg::ST_CAP : pwmpa_pkg::ST_MAX;
              end
            end
            pwmpa_pkg::OP_CHECK_HALF: begin
              if (live != '0) begin
                state_nxt = pwmpa_pkg::ST_CHECK;
              end
            end
            pwmpa_pkg::OP_CHANGE_REQ: begin
              cnt_nxt = cnt_r + 16'd1;
              if (cnt_r + 16'd1 == pwmpa_pkg::CHANGE_LIMIT) begin
                pend_nxt = pwmpa_pkg::STATUS_SAME_FREQ;
              end
            end
            pwmpa_pkg::OP_CHANGE_RST: begin
              if (cnt_r >= pwmpa_pkg::CHANGE_LIMIT) begin
                cnt_nxt  = '0;
                pend_nxt = pwmpa_pkg::STATUS_RESTORE;
              end
            end
            pwmpa_pkg::OP_READ_STATUS: begin
              stat_nxt = pend_r;
              pend_nxt = pwmpa_pkg::STATUS_NONE;
            end
            default: begin
              // read channel and the unused code change nothing
              state_nxt = pwmpa_pkg::ST_RESP;
            end
          endcase
        end
      end
      pwmpa_pkg::ST_MAX: begin
        top_nxt = step_out.top;
        if (last) begin
          idx_nxt   = '0;
          state_nxt = pwmpa_pkg::ST_CAP;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      pwmpa_pkg::ST_CAP: begin
        shared_nxt = step_out.shared;
        state_nxt  = (live == '0) ? pwmpa_pkg::ST_RESP : pwmpa_pkg::ST_ALLOC;
      end
      pwmpa_pkg::ST_ALLOC: begin
        half_nxt[idx_r]   = step_out.half;
        period_nxt[idx_r] = step_out.period;
        if (last) begin
          state_nxt = pwmpa_pkg::ST_RESP;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      pwmpa_pkg::ST_CHECK: begin
        flag_nxt[idx_r] = step_out.over_half;
        if (last) begin
          state_nxt = pwmpa_pkg::ST_RESP;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      pwmpa_pkg::ST_RESP: begin
        out_valid_nxt  = 1'b1;
        out_shared_nxt = shared_r;
        out_chg_nxt    = chg_r;
        out_stat_nxt   = stat_r;
        if (chan_ok(ch_r)) begin
          out_period_nxt = period_r[rd_idx];
          out_half_nxt   = half_r[rd_idx];
          out_over_nxt   = flag_r[rd_idx];
        end else begin
          out_period_nxt = '0;
          out_half_nxt   = '0;
          out_over_nxt   = 1'b0;
        end
        state_nxt = pwmpa_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = pwmpa_pkg::ST_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pwmpa_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Block state with reset values
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shared_r <= '0;
      cnt_r    <= '0;
      pend_r   <= pwmpa_pkg::STATUS_NONE;
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        half_r[i]   <= pwmpa_pkg::RST_START_HALF;
        period_r[i] <= pwmpa_pkg::RST_START_PERIOD;
        flag_r[i]   <= 1'b0;
      end
    end else begin
      shared_r <= shared_nxt;
      cnt_r    <= cnt_nxt;
      pend_r   <= pend_nxt;
      half_r   <= half_nxt;
      period_r <= period_nxt;
      flag_r   <= flag_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    ch_r         <= ch_nxt;
    chg_r        <= chg_nxt;
    stat_r       <= stat_nxt;
    top_r        <= top_nxt;
    out_shared_r <= out_shared_nxt;
    out_period_r <= out_period_nxt;
    out_half_r   <= out_half_nxt;
    out_over_r   <= out_over_nxt;
    out_chg_r    <= out_chg_nxt;
    out_stat_r   <= out_stat_nxt;
  end

  // Configuration writes; start half-period only acts through its reset default
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_active_r <= pwmpa_pkg::RST_ACTIVE;
      cfg_min_r    <= pwmpa_pkg::RST_MIN_HALF;
      cfg_max_r    <= pwmpa_pkg::RST_MAX_HALF;
      cfg_mask_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pwmpa_pkg::CFG_ACTIVE:     cfg_active_r <= cfg_data[2:0];
        pwmpa_pkg::CFG_MIN_HALF:   cfg_min_r    <= cfg_data;
        pwmpa_pkg::CFG_MAX_HALF:   cfg_max_r    <= cfg_data;
        pwmpa_pkg::CFG_START_HALF: cfg_mask_r   <= cfg_mask_r;
        pwmpa_pkg::CFG_INDEP_MASK: cfg_mask_r   <= cfg_data[3:0];
        default:                   cfg_mask_r   <= cfg_mask_r;
      endcase
    end
  end

  assign out_valid             = out_valid_r;
  assign out_shared_period     = out_shared_r;
  assign out_channel_period    = out_period_r;
  assign out_channel_half      = out_half_r;
  assign out_channel_over_half = out_over_r;
  assign out_change_out        = out_chg_r;
  assign out_status_code       = out_stat_r;

endmodule

`default_nettype wire
